// ===== sv/hierarchical_grid_box_index_top_macros.svh =====
// Assertion macros used by the checker file of the grid box index block.
`ifndef HIERARCHICAL_GRID_BOX_INDEX_TOP_MACROS_SVH
`define HIERARCHICAL_GRID_BOX_INDEX_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define HGBI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define HGBI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hgbi_pkg.sv =====
// Shared types and constants of the grid box index block.
`default_nettype none

package hgbi_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int DIMS_W    = 2;
  localparam int DEPTH_W   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMS      = 3'd0,
    CFG_MAX_DEPTH = 3'd1,
    CFG_CENTER_X  = 3'd2,
    CFG_CENTER_Y  = 3'd3,
    CFG_CENTER_Z  = 3'd4,
    CFG_LENGTH_X  = 3'd5,
    CFG_LENGTH_Y  = 3'd6,
    CFG_LENGTH_Z  = 3'd7
  } cfg_reg_e;

  // Effective dimension count and level count after saturation.
  typedef struct packed {
    logic [DIMS_W-1:0]  nd;
    logic [DEPTH_W-1:0] depth;
  } hgbi_mode_t;

  // Control that travels with each beat along the chain.
  typedef struct packed {
    logic valid;
    logic outside;
  } hgbi_ctl_t;

endpackage

`default_nettype wire

// ===== sv/hgbi_entry.sv =====
// Entry cell: scales the point and the centre, and checks the grid bounds.
`default_nettype none

module hgbi_entry
  import hgbi_pkg::*;
#(
  parameter int MAX_DIMS   = 3,
  parameter int MAX_LEVELS = 8,
  parameter int COORD_BITS = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire hgbi_mode_t              mode_i,
  input  wire logic [COORD_BITS-1:0]   cen_i   [MAX_DIMS],
  input  wire logic [COORD_BITS-2:0]   len_i   [MAX_DIMS],
  input  wire                          valid_i,
  output logic                         ready_o,
  input  wire logic [COORD_BITS-1:0]   coord_i [MAX_DIMS],
  output hgbi_ctl_t                    ctl_o,
  output logic [COORD_BITS-1:0]        p_o     [MAX_DIMS],
  output logic [COORD_BITS+MAX_LEVELS+1:0] m_o [MAX_DIMS],
  input  wire                          ready_i
);

  localparam int SS = MAX_LEVELS + 1;
  localparam int W  = COORD_BITS + MAX_LEVELS + 2;

  hgbi_ctl_t             ctl_q;
  logic [COORD_BITS-1:0] p_q   [MAX_DIMS];
  logic [W-1:0]          m_q   [MAX_DIMS];
  logic [W-1:0]          ps    [MAX_DIMS];
  logic [W-1:0]          cs    [MAX_DIMS];
  logic [W-1:0]          half  [MAX_DIMS];
  logic [W-1:0]          lo    [MAX_DIMS];
  logic [W-1:0]          hi    [MAX_DIMS];
  logic [MAX_DIMS-1:0]   out_d;
  logic                  outside;

  // All values are held scaled by 2^(MAX_LEVELS+1) so every halving is exact.
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      ps[d]   = {coord_i[d][COORD_BITS-1], coord_i[d], SS'(0)};
      cs[d]   = {cen_i[d][COORD_BITS-1], cen_i[d], SS'(0)};
      half[d] = {3'b000, len_i[d], MAX_LEVELS'(0)};
      lo[d]   = cs[d] - half[d];
      hi[d]   = cs[d] + half[d];
      out_d[d] = (DIMS_W'(d) < mode_i.nd) &&
                 (($signed(ps[d]) < $signed(lo[d])) || ($signed(ps[d]) > $signed(hi[d])));
    end
    outside = |out_d;
  end

  assign ready_o = !ctl_q.valid || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q.valid   <= valid_i;
      ctl_q.outside <= outside;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      p_q <= coord_i;
      m_q <= cs;
    end
  end

  assign ctl_o = ctl_q;
  assign p_o   = p_q;
  assign m_o   = m_q;

endmodule

`default_nettype wire

// ===== sv/hgbi_cell.sv =====
// Level cell: decides one level of the grid for every used dimension.
`default_nettype none

module hgbi_cell
  import hgbi_pkg::*;
#(
  parameter int MAX_DIMS   = 3,
  parameter int MAX_LEVELS = 8,
  parameter int COORD_BITS = 32,
  parameter int LEVEL      = 0
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire hgbi_mode_t              mode_i,
  input  wire logic [COORD_BITS-2:0]   len_i [MAX_DIMS],
  input  wire hgbi_ctl_t               ctl_i,
  output logic                         ready_o,
  input  wire logic [COORD_BITS-1:0]   p_i   [MAX_DIMS],
  input  wire logic [COORD_BITS+MAX_LEVELS+1:0] m_i [MAX_DIMS],
  input  wire logic [MAX_DIMS*MAX_LEVELS:0]     id_i,
  output hgbi_ctl_t                    ctl_o,
  output logic [COORD_BITS-1:0]        p_o   [MAX_DIMS],
  output logic [COORD_BITS+MAX_LEVELS+1:0] m_o [MAX_DIMS],
  output logic [MAX_DIMS*MAX_LEVELS:0]     id_o,
  input  wire                          ready_i
);

  localparam int SS   = MAX_LEVELS + 1;
  localparam int W    = COORD_BITS + MAX_LEVELS + 2;
  localparam int ID_W = MAX_DIMS * MAX_LEVELS + 1;
  localparam int QSH  = MAX_LEVELS - 1 - LEVEL;

  hgbi_ctl_t             ctl_q;
  logic [COORD_BITS-1:0] p_q   [MAX_DIMS];
  logic [W-1:0]          m_q   [MAX_DIMS];
  logic [ID_W-1:0]       id_q;
  logic [W-1:0]          ps    [MAX_DIMS];
  logic [W-1:0]          qtr   [MAX_DIMS];
  logic [W-1:0]          m_d   [MAX_DIMS];
  logic [MAX_DIMS-1:0]   grp;
  logic                  active;
  logic [ID_W-1:0]       id_d;

  // The quarter extent at this level is the scaled length shifted down by LEVEL+2.
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      ps[d]  = {p_i[d][COORD_BITS-1], p_i[d], SS'(0)};
      qtr[d] = W'(len_i[d]) << QSH;
      grp[d] = ($signed(ps[d]) > $signed(m_i[d])) && (DIMS_W'(d) < mode_i.nd);
      m_d[d] = ($signed(ps[d]) > $signed(m_i[d])) ? (m_i[d] + qtr[d]) : (m_i[d] - qtr[d]);
    end
    active = DEPTH_W'(LEVEL) < mode_i.depth;
    id_d   = active ? ((id_i << mode_i.nd) | ID_W'(grp)) : id_i;
  end

  assign ready_o = !ctl_q.valid || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid && ready_o) begin
      p_q  <= p_i;
      m_q  <= m_d;
      id_q <= id_d;
    end
  end

  assign ctl_o = ctl_q;
  assign p_o   = p_q;
  assign m_o   = m_q;
  assign id_o  = id_q;

endmodule

`default_nettype wire

// ===== sv/hierarchical_grid_box_index_top.sv =====
// Top level of the grid box index block: configuration, cell chain, output register.
//
// Usage: each input beat on in_valid_i/in_stall_o carries one point (coord_x_i,
// coord_y_i, coord_z_i, signed Q16.16). Each accepted beat yields exactly one
// output beat on out_valid_o/out_stall_i carrying box_id_o and out_of_range_o,
// in order. Coordinates of dimensions beyond dims are ignored.
// From the accepting edge to the output beat, the beat passes one entry cell that
// does the bounds check, one cell per grid level, and the output register.
// Throughput is one point per cycle; every cell is a pipeline stage with its own
// valid bit, so a new point enters each cycle while the chain keeps moving.
// When the receiver stalls, the output register holds its beat and the chain
// fills up behind it; in_stall_o rises only once every cell is occupied.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i, and
// must only change while no point is in flight.
// Reset empties the chain and the output register and loads dims = 3,
// max_depth = 8, centres 0 and lengths 1.0 (65536 in Q16.16).
`default_nettype none

module hierarchical_grid_box_index_top
  import hgbi_pkg::*;
#(
  parameter int MAX_DIMS   = 3,
  parameter int MAX_LEVELS = 8,
  parameter int COORD_BITS = 32
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]      cfg_wdata_i,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [COORD_BITS-1:0]      coord_x_i,
  input  wire logic [COORD_BITS-1:0]      coord_y_i,
  input  wire logic [COORD_BITS-1:0]      coord_z_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [MAX_DIMS*MAX_LEVELS:0]    box_id_o,
  output logic                            out_of_range_o
);

  localparam int W    = COORD_BITS + MAX_LEVELS + 2;
  localparam int ID_W = MAX_DIMS * MAX_LEVELS + 1;
  localparam int NS   = MAX_LEVELS + 1;

  logic [DIMS_W-1:0]     dims_q;
  logic [DEPTH_W-1:0]    depth_q;
  logic [COORD_BITS-1:0] cen_q [MAX_DIMS];
  logic [COORD_BITS-2:0] len_q [MAX_DIMS];
  hgbi_mode_t            mode;

  logic [COORD_BITS-1:0] coord_all [3];
  logic [COORD_BITS-1:0] coord     [MAX_DIMS];

  hgbi_ctl_t             ctl_s [NS];
  logic                  rdy_s [NS+1];
  logic [COORD_BITS-1:0] p_s   [NS][MAX_DIMS];
  logic [W-1:0]          m_s   [NS][MAX_DIMS];
  logic [ID_W-1:0]       id_s  [NS];

  logic                  out_valid_q;
  logic [ID_W-1:0]       box_id_q;
  logic                  oor_q;
  logic [5:0]            oor_sh;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= DIMS_W'(3);
      depth_q <= DEPTH_W'(8);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DIMS:      dims_q  <= cfg_wdata_i[DIMS_W-1:0];
        CFG_MAX_DEPTH: depth_q <= cfg_wdata_i[DEPTH_W-1:0];
        default:       ;
      endcase
    end
  end

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cfg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cen_q[d] <= '0;
        len_q[d] <= (COORD_BITS-1)'(65536);
      end else if (cfg_we_i) begin
        if (cfg_idx_i == (CFG_CENTER_X + CFG_IDX_W'(d))) begin
          cen_q[d] <= cfg_wdata_i;
        end
        if (cfg_idx_i == (CFG_LENGTH_X + CFG_IDX_W'(d))) begin
          len_q[d] <= cfg_wdata_i[COORD_BITS-2:0];
        end
      end
    end
  end

  // A zero count means one, and counts above the build limits saturate.
  always_comb begin
    if (dims_q == '0) begin
      mode.nd = DIMS_W'(1);
    end else if (dims_q > DIMS_W'(MAX_DIMS)) begin
      mode.nd = DIMS_W'(MAX_DIMS);
    end else begin
      mode.nd = dims_q;
    end
    if (depth_q == '0) begin
      mode.depth = DEPTH_W'(1);
    end else if (depth_q > DEPTH_W'(MAX_LEVELS)) begin
      mode.depth = DEPTH_W'(MAX_LEVELS);
    end else begin
      mode.depth = depth_q;
    end
  end

  assign coord_all[0] = coord_x_i;
  assign coord_all[1] = coord_y_i;
  assign coord_all[2] = coord_z_i;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_coord
    assign coord[d] = coord_all[d];
  end

  hgbi_entry #(
    .MAX_DIMS   (MAX_DIMS),
    .MAX_LEVELS (MAX_LEVELS),
    .COORD_BITS (COORD_BITS)
  ) u_entry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode),
    .cen_i   (cen_q),
    .len_i   (len_q),
    .valid_i (in_valid_i),
    .ready_o (rdy_s[0]),
    .coord_i (coord),
    .ctl_o   (ctl_s[0]),
    .p_o     (p_s[0]),
    .m_o     (m_s[0]),
    .ready_i (rdy_s[1])
  );

  assign id_s[0]    = '0;
  assign in_stall_o = !rdy_s[0];

  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_level
    hgbi_cell #(
      .MAX_DIMS   (MAX_DIMS),
      .MAX_LEVELS (MAX_LEVELS),
      .COORD_BITS (COORD_BITS),
      .LEVEL      (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mode_i  (mode),
      .len_i   (len_q),
      .ctl_i   (ctl_s[k]),
      .ready_o (rdy_s[k+1]),
      .p_i     (p_s[k]),
      .m_i     (m_s[k]),
      .id_i    (id_s[k]),
      .ctl_o   (ctl_s[k+1]),
      .p_o     (p_s[k+1]),
      .m_o     (m_s[k+1]),
      .id_o    (id_s[k+1]),
      .ready_i (rdy_s[k+2])
    );
  end

  // Output register; an out-of-range point reports one past the largest id.
  assign rdy_s[NS] = !out_valid_q || !out_stall_i;
  assign oor_sh    = 6'(mode.nd) * 6'(mode.depth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy_s[NS]) begin
      out_valid_q <= ctl_s[NS-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_s[NS-1].valid && rdy_s[NS]) begin
      box_id_q <= ctl_s[NS-1].outside ? (ID_W'(1) << oor_sh) : id_s[NS-1];
      oor_q    <= ctl_s[NS-1].outside;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign box_id_o       = box_id_q;
  assign out_of_range_o = oor_q;

endmodule

`default_nettype wire

// ===== sv/hgbi_checker.sv =====
// Port-level checker for the grid box index block and its bind statement.
`default_nettype none
`include "hierarchical_grid_box_index_top_macros.svh"

module hgbi_checker #(
  parameter int MAX_DIMS   = 3,
  parameter int MAX_LEVELS = 8
) (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_stall_o,
  input wire                          out_valid_o,
  input wire                          out_stall_i,
  input wire [MAX_DIMS*MAX_LEVELS:0]  box_id_o,
  input wire                          out_of_range_o
);

  // An out-of-range beat carries a single power of two as its id.
  `HGBI_ASSERT_IMP(a_oor_onehot, out_valid_o && out_of_range_o, $onehot(box_id_o), "out-of-range id is not a power of two")

  // An in-range id never reaches the top bit.
  `HGBI_ASSERT_IMP(a_id_top_clear, out_valid_o && !out_of_range_o, !box_id_o[MAX_DIMS*MAX_LEVELS], "in-range id has its top bit set")

  // With the output register empty, the whole chain can move, so input is taken.
  `HGBI_ASSERT_IMP(a_no_stall_empty, !out_valid_o, !in_stall_o, "input stalled while the output is empty")

  // A stalled output beat stays in place.
  `HGBI_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(box_id_o) && $stable(out_of_range_o), "stalled output beat changed")

endmodule

bind hierarchical_grid_box_index_top hgbi_checker #(
  .MAX_DIMS   (MAX_DIMS),
  .MAX_LEVELS (MAX_LEVELS)
) u_hgbi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .box_id_o       (box_id_o),
  .out_of_range_o (out_of_range_o)
);

`default_nettype wire
